// ----- sv/cpsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsm_pkg
// Shared types and constants for the class pattern stream matcher.
// ----------------------------------------------------------------------------
package cpsm_pkg;

  localparam int MAX_TOKENS_DEF    = 7;
  localparam int SET_MEMBERS_DEF   = 7;
  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam int TOKEN_BITS        = 62;
  localparam int MEMBER_SLOTS      = 7;
  localparam int COUNT_BITS        = 3;
  localparam int REG_INDEX_BITS    = 3;
  localparam int START_BITS        = 16;

  localparam logic [REG_INDEX_BITS-1:0] REG_TOKEN_COUNT = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_TOKEN_FIRST = 3'd1;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

  typedef logic [TOKEN_BITS-1:0] token_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [2:0] {
    KIND_LITERAL = 3'd0,
    KIND_ANY     = 3'd1,
    KIND_LOWER   = 3'd2,
    KIND_UPPER   = 3'd3,
    KIND_SET     = 3'd4,
    KIND_NEGSET  = 3'd5
  } token_kind_t;

  typedef struct packed {
    logic                  found;
    logic [START_BITS-1:0] match_start;
    logic                  position_overflow;
  } result_t;

endpackage

// ----- sv/class_pattern_stream_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_pattern_stream_matcher
// Finds the first match of a short character-class pattern in a byte stream.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while in_stall is low and gives one result
// per text: the start of the first match, or a not-found result on the byte
// marked end_of_text. A classifier compares each byte against all tokens in
// the cycle it is transferred and pushes the hit vector into a two-entry
// queue; the shift-and engine takes one entry per cycle unless a result is
// held, and registers a result as its completing entry leaves the queue.
// While a result waits there, bytes that cause no result keep flowing and
// the queue absorbs up to two more. Write configuration only while idle.
module class_pattern_stream_matcher #(
  parameter int MAX_TOKENS    = cpsm_pkg::MAX_TOKENS_DEF,
  parameter int SET_MEMBERS   = cpsm_pkg::SET_MEMBERS_DEF,
  parameter int POSITION_BITS = cpsm_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [cpsm_pkg::REG_INDEX_BITS-1:0] cfg_index,
  input  logic [cpsm_pkg::TOKEN_BITS-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          text_byte,
  input  logic                                end_of_text,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [cpsm_pkg::START_BITS-1:0]     match_start,
  output logic                                position_overflow
);
  import cpsm_pkg::*;

  count_t              token_count;
  token_t              tokens [MAX_TOKENS];

  logic                push;
  logic [MAX_TOKENS:0] push_data;
  logic                queue_full;
  logic                pop;
  logic [MAX_TOKENS:0] pop_data;
  logic                queue_empty;
  result_t             result;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_count <= COUNT_BITS'(1);
      for (int k = 0; k < MAX_TOKENS; k++) begin
        tokens[k] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_TOKEN_COUNT) begin
        token_count <= cfg_data[COUNT_BITS-1:0];
      end
      for (int k = 0; k < MAX_TOKENS; k++) begin
        if (cfg_index == REG_TOKEN_FIRST + REG_INDEX_BITS'(k)) begin
          tokens[k] <= cfg_data;
        end
      end
    end
  end

  cpsm_front #(
    .MAX_TOKENS  (MAX_TOKENS),
    .SET_MEMBERS (SET_MEMBERS)
  ) u_front (
    .tokens      (tokens),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .queue_full  (queue_full),
    .push        (push),
    .push_data   (push_data)
  );

  cpsm_queue #(
    .WIDTH (MAX_TOKENS + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  cpsm_back #(
    .MAX_TOKENS    (MAX_TOKENS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .token_count (token_count),
    .queue_empty (queue_empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign found             = result.found;
  assign match_start       = result.match_start;
  assign position_overflow = result.position_overflow;

endmodule

// ----- sv/cpsm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsm_queue
// Small first-in first-out queue between the classifier and the match engine.
// ----------------------------------------------------------------------------
module cpsm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/cpsm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsm_front
// Accepts text bytes and compares each against every pattern token at once.
// ----------------------------------------------------------------------------
module cpsm_front #(
  parameter int MAX_TOKENS  = cpsm_pkg::MAX_TOKENS_DEF,
  parameter int SET_MEMBERS = cpsm_pkg::SET_MEMBERS_DEF
) (
  input  cpsm_pkg::token_t      tokens [MAX_TOKENS],
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_text,
  input  logic                  queue_full,
  output logic                  push,
  output logic [MAX_TOKENS:0]   push_data
);
  import cpsm_pkg::*;

  function automatic logic token_hit(token_t tok, logic [7:0] c);
    count_t cnt;
    logic   in_set;
    logic   hit;
    cnt    = (tok[5:3] > COUNT_BITS'(SET_MEMBERS)) ? COUNT_BITS'(SET_MEMBERS) : tok[5:3];
    in_set = 1'b0;
    for (int m = 0; m < MEMBER_SLOTS; m++) begin
      if ((COUNT_BITS'(m) < cnt) && (tok[6 + 8*m +: 8] == c)) begin
        in_set = 1'b1;
      end
    end
    case (token_kind_t'(tok[2:0]))
      KIND_LITERAL: hit = (tok[13:6] == c);
      KIND_ANY:     hit = 1'b1;
      KIND_LOWER:   hit = c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
      KIND_UPPER:   hit = c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
      KIND_SET:     hit = in_set;
      KIND_NEGSET:  hit = !in_set;
      default:      hit = 1'b0;
    endcase
    return hit;
  endfunction

  logic [MAX_TOKENS-1:0] hits;

  always_comb begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      hits[k] = token_hit(tokens[k], text_byte);
    end
  end

  assign in_stall  = queue_full;
  assign push      = in_valid && !queue_full;
  assign push_data = {end_of_text, hits};

endmodule

// ----- sv/cpsm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsm_back
// Shift-and match engine, position counter and result register.
// ----------------------------------------------------------------------------
module cpsm_back #(
  parameter int MAX_TOKENS    = cpsm_pkg::MAX_TOKENS_DEF,
  parameter int POSITION_BITS = cpsm_pkg::POSITION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cpsm_pkg::count_t      token_count,
  input  logic                  queue_empty,
  input  logic [MAX_TOKENS:0]   queue_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cpsm_pkg::result_t     result
);
  import cpsm_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [MAX_TOKENS-1:0]    pmv;
  logic [POSITION_BITS-1:0] pos;
  logic                     reported;
  logic                     overflow;

  logic [MAX_TOKENS-1:0]    pmv_next;
  logic [POSITION_BITS-1:0] pos_next;
  logic                     reported_next;
  logic                     overflow_next;

  logic [MAX_TOKENS-1:0]    hits;
  logic                     eot;
  count_t                   n;
  logic [MAX_TOKENS-1:0]    mask;
  logic [MAX_TOKENS-1:0]    top;
  logic [MAX_TOKENS-1:0]    vec;
  logic                     hit;
  logic [POSITION_BITS-1:0] span;
  logic [POSITION_BITS-1:0] start;
  logic [POSITION_BITS+START_BITS-1:0] start_wide;
  logic                     emit;
  logic                     out_free;
  result_t                  res_next;

  assign hits     = queue_data[MAX_TOKENS-1:0];
  assign eot      = queue_data[MAX_TOKENS];
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (token_count == '0) begin
      n = COUNT_BITS'(1);
    end else if (token_count > COUNT_BITS'(MAX_TOKENS)) begin
      n = COUNT_BITS'(MAX_TOKENS);
    end else begin
      n = token_count;
    end
    for (int k = 0; k < MAX_TOKENS; k++) begin
      mask[k] = (COUNT_BITS'(k) < n);
      top[k]  = (COUNT_BITS'(k + 1) == n);
    end
  end

  always_comb begin
    vec        = {pmv[MAX_TOKENS-2 >= 0 ? MAX_TOKENS-2 : 0:0], 1'b1} & hits & mask;
    hit        = |(vec & top) && !reported;
    span       = POSITION_BITS'(n - 1'b1);
    start      = (pos >= span) ? pos - span : '0;
    start_wide = {{START_BITS{1'b0}}, start};

    emit = !reported && (hit || eot);
    pop  = !queue_empty && (!emit || out_free);

    pmv_next      = pmv;
    pos_next      = pos;
    reported_next = reported;
    overflow_next = overflow;

    res_next.found             = hit;
    res_next.match_start       = hit ? start_wide[START_BITS-1:0] : '0;
    res_next.position_overflow = overflow;

    if (eot && (reported || hit || !reported)) begin
      pmv_next      = '0;
      pos_next      = '0;
      reported_next = 1'b0;
      overflow_next = 1'b0;
    end
    if (!eot && !reported) begin
      if (pos == POS_MAX) begin
        overflow_next = 1'b1;
      end else begin
        pos_next = pos + 1'b1;
      end
      if (hit) begin
        pmv_next      = '0;
        reported_next = 1'b1;
      end else begin
        pmv_next = vec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pmv       <= '0;
      pos       <= '0;
      reported  <= 1'b0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pmv      <= pmv_next;
        pos      <= pos_next;
        reported <= reported_next;
        overflow <= overflow_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      result <= res_next;
    end
  end

endmodule

// ----- sv/cpsm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsm_checker
// Port-level checks for the class pattern stream matcher.
// ----------------------------------------------------------------------------
module cpsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [15:0] match_start,
  input logic        position_overflow
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_start)
      && $stable(position_overflow))
    else $error("result changed while stalled");

  // a not-found transfer carries a zero start
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_start == 16'd0)
    else $error("not-found result with nonzero start");

  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind class_pattern_stream_matcher cpsm_checker u_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the class pattern stream matcher.
// ----------------------------------------------------------------------------
// A queue of byte transfers and register writes is built at time zero: a
// directed opening over every token kind and the end-of-text, repeat-match,
// count-change and empty-set corners, then random pattern phases. A clocked
// driver feeds the queue and keeps a shift-and model of the matcher; a
// clocked monitor checks every result transfer against that model. Both
// sides insert random idle bursts except in the closing phases.
// ----------------------------------------------------------------------------
module tb_top;
  import cpsm_pkg::*;

  localparam logic [2:0] KIND_RESERVED_6 = 3'd6;
  localparam token_t     TOKEN_ALL_ONES  = '1;
  localparam int         DRAIN_CYCLES    = 8;
  localparam int         PHASE_BYTES     = 50;

  typedef struct {
    bit                        is_cfg;
    bit                        calm;
    logic [REG_INDEX_BITS-1:0] idx;
    token_t                    data;
    logic [7:0]                chr;
    logic                      eot;
  } feed_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [REG_INDEX_BITS-1:0] cfg_index = '0;
  logic [TOKEN_BITS-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                text_byte = '0;
  logic                      end_of_text = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      found;
  logic [START_BITS-1:0]     match_start;
  logic                      position_overflow;

  feed_t   pending_feed[$];
  result_t pending_results[$];
  int      err_cnt = 0;
  logic    calm_mode = 1'b0;

  // matcher model
  count_t      model_count = count_t'(1);
  token_t      model_tok[MAX_TOKENS_DEF] = '{default: '0};
  logic [6:0]  model_vec = '0;
  logic [15:0] model_pos = '0;
  logic        model_reported = 1'b0;
  logic        model_ovf = 1'b0;

  // stimulus plan for the current phase
  token_t plan_tok[MAX_TOKENS_DEF];
  int     plan_n;
  string  char_pool = "[^].\\aAzZ";

  class_pattern_stream_matcher u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .text_byte        (text_byte),
    .end_of_text      (end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .match_start      (match_start),
    .position_overflow(position_overflow)
  );

  always #5 clk = ~clk;

  function automatic token_t make_token(input logic [2:0] kind, input int cnt,
                                        input logic [55:0] mem);
    return {mem, 3'(cnt), kind};
  endfunction

  function automatic bit token_accepts(input token_t tok, input logic [7:0] ch);
    int cnt;
    bit in_set;
    cnt = tok[5:3];
    in_set = 1'b0;
    for (int m = 0; m < cnt; m++)
      if (tok[6 + 8 * m +: 8] == ch) in_set = 1'b1;
    case (tok[2:0])
      KIND_LITERAL: return tok[13:6] == ch;
      KIND_ANY:     return 1'b1;
      KIND_LOWER:   return ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z;
      KIND_UPPER:   return ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z;
      KIND_SET:     return in_set;
      KIND_NEGSET:  return !in_set;
      default:      return 1'b0;
    endcase
  endfunction

  task automatic clear_model();
    model_vec = '0;
    model_pos = '0;
    model_reported = 1'b0;
    model_ovf = 1'b0;
  endtask

  task automatic apply_cfg(input logic [REG_INDEX_BITS-1:0] idx, input token_t data);
    if (idx == REG_TOKEN_COUNT) model_count = data[2:0];
    else model_tok[idx - REG_TOKEN_FIRST] = data;
  endtask

  // one accepted byte through the shift-and model
  task automatic advance_bitap(input logic [7:0] ch, input logic eot);
    int          n;
    logic [6:0]  hits;
    logic [6:0]  mask;
    logic [15:0] pos_now;
    logic        ovf_now;
    result_t     r;
    n = (model_count == 0) ? 1 : model_count;
    if (model_reported) begin
      if (eot) clear_model();
      return;
    end
    hits = '0;
    for (int k = 0; k < n; k++) hits[k] = token_accepts(model_tok[k], ch);
    mask = 7'((1 << n) - 1);
    pos_now = model_pos;
    ovf_now = model_ovf;
    model_vec = ((model_vec << 1) | 7'd1) & hits & mask;
    if (model_pos == 16'hFFFF) model_ovf = 1'b1;
    else model_pos++;
    if (model_vec[n - 1]) begin
      r.found = 1'b1;
      r.match_start = (pos_now >= n - 1) ? pos_now - 16'(n - 1) : '0;
      r.position_overflow = ovf_now;
      pending_results.push_back(r);
      if (eot) clear_model();
      else begin
        model_vec = '0;
        model_reported = 1'b1;
      end
    end else if (eot) begin
      r.found = 1'b0;
      r.match_start = '0;
      r.position_overflow = ovf_now;
      pending_results.push_back(r);
      clear_model();
    end
  endtask

  task automatic add_byte(input logic [7:0] ch, input logic eot, input bit calm);
    feed_t f;
    f = '{is_cfg: 1'b0, calm: calm, idx: '0, data: '0, chr: ch, eot: eot};
    pending_feed.push_back(f);
  endtask

  task automatic add_text(input string s, input bit eot_last, input bit calm);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i], eot_last && (i == s.len() - 1), calm);
  endtask

  task automatic add_cfg(input logic [REG_INDEX_BITS-1:0] idx, input token_t data);
    feed_t f;
    f = '{is_cfg: 1'b1, calm: 1'b0, idx: idx, data: data, chr: '0, eot: 1'b0};
    pending_feed.push_back(f);
  endtask

  function automatic token_t random_token();
    logic [2:0]  kind;
    logic [55:0] mem;
    int          pick;
    pick = $urandom_range(0, 15);
    if (pick < 4) kind = KIND_LITERAL;
    else if (pick < 6) kind = KIND_ANY;
    else if (pick < 8) kind = KIND_LOWER;
    else if (pick < 10) kind = KIND_UPPER;
    else if (pick < 13) kind = KIND_SET;
    else if (pick < 15) kind = KIND_NEGSET;
    else kind = 3'($urandom_range(KIND_RESERVED_6, 7));
    for (int m = 0; m < 7; m++)
      mem[8 * m +: 8] = $urandom_range(0, 1) ?
                        char_pool[$urandom_range(0, char_pool.len() - 1)] :
                        8'($urandom_range(0, 255));
    return make_token(kind, $urandom_range(0, 7), mem);
  endfunction

  // a byte that the token most likely accepts
  function automatic logic [7:0] sample_hit(input token_t tok);
    int cnt;
    cnt = tok[5:3];
    case (tok[2:0])
      KIND_LITERAL: return tok[13:6];
      KIND_LOWER:   return CHAR_LOWER_A + 8'($urandom_range(0, 25));
      KIND_UPPER:   return CHAR_UPPER_A + 8'($urandom_range(0, 25));
      KIND_SET:     return (cnt == 0) ? 8'($urandom_range(0, 255)) :
                           tok[6 + 8 * $urandom_range(0, cnt - 1) +: 8];
      default:      return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] fill_byte();
    if ($urandom_range(0, 4) < 2) return 8'($urandom_range(0, 255));
    return sample_hit(plan_tok[$urandom_range(0, plan_n - 1)]);
  endfunction

  task automatic add_queue_text(ref logic [7:0] txt[$], input bit calm);
    for (int i = 0; i < txt.size(); i++) add_byte(txt[i], i == txt.size() - 1, calm);
  endtask

  // driver: register writes and byte transfers
  always @(posedge clk) begin : drv
    feed_t f;
    logic  nxt_valid;
    logic  wr;
    int    gap_cnt;
    int    quiet_cnt;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_write <= 1'b0;
      gap_cnt = 0;
      quiet_cnt = 0;
    end else begin
      nxt_valid = in_valid;
      wr = 1'b0;
      if (in_valid && !in_stall) begin
        advance_bitap(text_byte, end_of_text);
        nxt_valid = 1'b0;
      end
      if (!in_valid && pending_results.size() == 0) quiet_cnt++;
      else quiet_cnt = 0;
      if (!nxt_valid && pending_feed.size() != 0) begin
        if (gap_cnt != 0) gap_cnt--;
        else if (pending_feed[0].is_cfg) begin
          if (quiet_cnt >= DRAIN_CYCLES) begin
            f = pending_feed.pop_front();
            apply_cfg(f.idx, f.data);
            cfg_index <= f.idx;
            cfg_data <= f.data;
            wr = 1'b1;
          end
        end else begin
          f = pending_feed.pop_front();
          text_byte <= f.chr;
          end_of_text <= f.eot;
          calm_mode <= f.calm;
          nxt_valid = 1'b1;
          if (!f.calm && $urandom_range(0, 5) == 0) gap_cnt = $urandom_range(1, 12);
        end
      end
      in_valid <= nxt_valid;
      cfg_write <= wr;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // monitor: result transfers and receiver stalls
  always @(posedge clk) begin : mon
    result_t want;
    int      stall_cnt;
    if (rst) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("t=%0t unexpected result: expected none, actual found=%0b start=%0d ovf=%0b",
                   $time, found, match_start, position_overflow);
        end else begin
          want = pending_results.pop_front();
          check_field("found", want.found, found);
          check_field("match_start", want.match_start, match_start);
          check_field("position_overflow", want.position_overflow, position_overflow);
        end
      end
      if (stall_cnt != 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else if (!calm_mode && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("class_pattern_stream_matcher regression: fail");
    $finish;
  end

  initial begin
    int         cnt_val;
    int         pick;
    int         used;
    int         j;
    bit         calm;
    token_t     data;
    logic [7:0] txt[$];

    // directed: reset pattern is a single literal zero byte, hit on the last byte
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);

    // every kind across the registers; match, then bytes after the report
    add_cfg(REG_TOKEN_COUNT, token_t'(4));
    add_cfg(3'(REG_TOKEN_FIRST + 0), make_token(KIND_UPPER, 0, '0));
    add_cfg(3'(REG_TOKEN_FIRST + 1), make_token(KIND_SET, 3, {32'h0, "[^]"}));
    add_cfg(3'(REG_TOKEN_FIRST + 2), make_token(KIND_NEGSET, 2, {40'h0, ".\\"}));
    add_cfg(3'(REG_TOKEN_FIRST + 3), make_token(KIND_LOWER, 0, '0));
    add_cfg(3'(REG_TOKEN_FIRST + 4), make_token(KIND_ANY, 0, '0));
    add_cfg(3'(REG_TOKEN_FIRST + 5), TOKEN_ALL_ONES);
    add_cfg(3'(REG_TOKEN_FIRST + 6), '0);
    add_text("xQ^!aZ", 1'b1, 1'b0);
    add_text("Q].b", 1'b1, 1'b0);

    // token count shrinks in the middle of a text
    add_text("Q^", 1'b0, 1'b0);
    add_cfg(REG_TOKEN_COUNT, token_t'(3));
    add_text("!x", 1'b1, 1'b0);

    // count zero acts as one; empty negated set, unused kinds, empty set
    add_cfg(REG_TOKEN_COUNT, token_t'(0));
    add_cfg(REG_TOKEN_FIRST, make_token(KIND_NEGSET, 0, {7{"q"}}));
    add_text("km", 1'b1, 1'b0);
    add_cfg(REG_TOKEN_FIRST, TOKEN_ALL_ONES);
    add_text("q", 1'b1, 1'b0);
    add_cfg(REG_TOKEN_FIRST, make_token(KIND_RESERVED_6, 1, {7{"q"}}));
    add_text("q", 1'b1, 1'b0);
    add_cfg(REG_TOKEN_FIRST, make_token(KIND_SET, 0, {7{"q"}}));
    add_text("q", 1'b1, 1'b0);

    // full-length pattern completing on the last byte
    add_cfg(REG_TOKEN_COUNT, token_t'(7));
    for (int k = 0; k < MAX_TOKENS_DEF; k++)
      add_cfg(3'(REG_TOKEN_FIRST + k), make_token(KIND_ANY, 0, '0));
    add_text("abcdefg", 1'b1, 1'b0);

    // random pattern phases
    for (int phase = 0; phase < 12; phase++) begin
      calm = (phase >= 10);
      cnt_val = (phase == 0) ? 7 : (phase == 1) ? 0 : $urandom_range(1, 7);
      data = token_t'({$urandom, $urandom});
      data[2:0] = 3'(cnt_val);
      add_cfg(REG_TOKEN_COUNT, data);
      for (int k = 0; k < MAX_TOKENS_DEF; k++) begin
        plan_tok[k] = random_token();
        add_cfg(3'(REG_TOKEN_FIRST + k), plan_tok[k]);
      end
      plan_n = (cnt_val == 0) ? 1 : cnt_val;
      used = 0;
      while (used < PHASE_BYTES) begin
        txt.delete();
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          repeat ($urandom_range(0, 6)) txt.push_back(fill_byte());
          for (int k = 0; k < plan_n; k++) txt.push_back(sample_hit(plan_tok[k]));
          repeat ($urandom_range(0, 3)) txt.push_back(fill_byte());
        end else if (pick < 9) begin
          repeat ($urandom_range(0, 3)) txt.push_back(fill_byte());
          j = $urandom_range(0, plan_n - 1);
          for (int k = 0; k < j; k++) txt.push_back(sample_hit(plan_tok[k]));
          txt.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom_range(0, 255)));
        end
        add_queue_text(txt, calm);
        used += txt.size();
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_feed.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_cnt++;
      $display("t=%0t missing results: expected 0 pending, actual %0d pending",
               $time, pending_results.size());
    end
    if (err_cnt == 0) $display("class_pattern_stream_matcher regression: pass");
    else $display("class_pattern_stream_matcher regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cpsm_pkg.sv
sv/cpsm_queue.sv
sv/cpsm_front.sv
sv/cpsm_back.sv
sv/class_pattern_stream_matcher.sv
sv/cpsm_checker.sv
verif/tb_top.sv
